/* hw/rtl/glla_pkg.sv */
// shared constants and types for the least-loaded assigner
package glla_pkg;
    localparam int MAX_PES_DEF = 64;
    localparam int LOAD_FRAC_BITS_DEF = 16;
    localparam int LOAD_W = 32;
    localparam int SPEED_W = 16;
    localparam int ID_W = 16;
    localparam int IDX_W = 6;
    localparam int ACT_W = 7;
    localparam int PROD_W = LOAD_W + SPEED_W;
    localparam int IN_W = 112;
    localparam int OUT_W = 32;

    localparam logic [1:0] ST_PLACED = 2'd0;
    localparam logic [1:0] ST_KEPT = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    localparam logic OP_SETUP = 1'b0;
    localparam logic OP_PLACE = 1'b1;

    typedef struct packed {
        logic load_req;
        logic setup_wr;
        logic scan_start;
        logic scan_step;
        logic mul_start;
        logic div_start;
        logic div_step;
        logic commit;
        logic out_load;
    } glla_cmd_t;

    typedef struct packed {
        logic is_setup;
        logic mig;
        logic scan_done;
        logic div_done;
    } glla_sts_t;
endpackage

/* hw/rtl/greedy_least_loaded_assigner.sv */
// top level of the greedy least-loaded assigner
//
// channel   dir  handshake            contents
// s_axis    in   s_tvalid/s_tready    one request: setup or place
// m_axis    out  m_tvalid/m_tready    one placement result per place request
// cfg       in   cfg_valid/cfg_ready  active_pes register
//
// setup request: decode, then table write; non-migratable: decode, then result, plus output wait
// migratable: time set by the table scan over the clamped active_pes entries
// (one entry a cycle) and the 48-step restoring divider
// reset: active_pes 64, loads 0, speeds 1, all ready; no clearing pass
// the result register frees the core while a result waits to be taken
module greedy_least_loaded_assigner (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pe_index, background_load, speed_value, pe_available,
    // object_id, object_time, current_pe, migratable
    input  logic [111:0] s_tdata,
    // operation
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // placed_object, destination_pe, moved, status
    output logic [31:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [6:0]   cfg_data
);
    glla_pkg::glla_cmd_t cmd;
    glla_pkg::glla_sts_t sts;
    logic [glla_pkg::ACT_W-1:0] active_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= 7'd64;
        else if (cfg_valid)
            active_reg <= cfg_data;
    end

    glla_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .sts(sts), .cmd(cmd)
    );

    glla_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .req_data({s_tdata[110:0], s_tuser}), .active_pes(active_reg), .res_data(m_tdata)
    );
endmodule

/* hw/rtl/glla_datapath.sv */
// table memories, min-load scan, multiply, serial divide and result register
module glla_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  glla_pkg::glla_cmd_t      cmd,
    output glla_pkg::glla_sts_t      sts,
    input  logic [glla_pkg::IN_W-1:0] req_data,
    input  logic [glla_pkg::ACT_W-1:0] active_pes,
    output logic [glla_pkg::OUT_W-1:0] res_data
);
    localparam int MAX_PES = glla_pkg::MAX_PES_DEF;
    localparam int AW = (MAX_PES > 1) ? $clog2(MAX_PES) : 1;
    localparam int CW = AW + 1;
    localparam int PW = glla_pkg::PROD_W;
    localparam int DCW = $clog2(PW + 1);

    logic [glla_pkg::LOAD_W-1:0] load_mem [MAX_PES];
    logic [glla_pkg::SPEED_W-1:0] speed_mem [MAX_PES];
    logic [MAX_PES-1:0] written_reg;
    logic [MAX_PES-1:0] ready_reg;

    logic op_reg, mig_reg;
    logic [glla_pkg::IDX_W-1:0] idx_reg, cur_reg;
    logic [glla_pkg::LOAD_W-1:0] bg_reg, otime_reg;
    logic [glla_pkg::SPEED_W-1:0] spd_reg;
    logic avail_reg;
    logic [glla_pkg::ID_W-1:0] id_reg;

    logic [CW-1:0] cnt_reg, lim_reg;
    logic [AW-1:0] best_reg;
    logic [glla_pkg::LOAD_W-1:0] best_load_reg, rd_load_reg;
    logic [glla_pkg::SPEED_W-1:0] rd_speed_reg;
    logic rd_valid_reg, rd_written_reg;
    logic [AW-1:0] rd_addr_reg;
    logic [PW-1:0] prod_reg, quot_reg;
    logic [glla_pkg::SPEED_W:0] rem_reg;
    logic [glla_pkg::SPEED_W-1:0] dsp_reg;
    logic [DCW-1:0] dcnt_reg;
    logic [glla_pkg::OUT_W-1:0] res_reg;

    logic cur_ok;
    logic [CW-1:0] lim_next;
    logic [AW-1:0] rd_addr;
    logic [glla_pkg::LOAD_W-1:0] rd_load_eff;
    logic [glla_pkg::SPEED_W:0] rem_sh;
    logic [PW:0] sum;
    logic [glla_pkg::LOAD_W-1:0] new_load;

    assign cur_ok = (MAX_PES >= 64) || ({26'd0, cur_reg} < 32'(MAX_PES));

    always_comb
    begin
        lim_next = (active_pes == '0) ? CW'(1) : CW'(active_pes);
        if (32'(active_pes) > 32'(MAX_PES))
            lim_next = CW'(MAX_PES);
    end

    assign rd_addr = cnt_reg[AW-1:0];
    assign rd_load_eff = rd_written_reg ? rd_load_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            ready_reg <= '1;
        end
        else if (cmd.setup_wr && ({26'd0, idx_reg} < 32'(MAX_PES)))
        begin
            written_reg[idx_reg[AW-1:0]] <= 1'b1;
            ready_reg[idx_reg[AW-1:0]] <= avail_reg;
        end
        else if (cmd.commit)
            written_reg[best_reg] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.setup_wr && ({26'd0, idx_reg} < 32'(MAX_PES)))
        begin
            load_mem[idx_reg[AW-1:0]] <= bg_reg;
            speed_mem[idx_reg[AW-1:0]] <= spd_reg;
        end
        else if (cmd.commit)
        begin
            load_mem[best_reg] <= new_load;
            if (!written_reg[best_reg])
                speed_mem[best_reg] <= 16'd1;
        end
        rd_load_reg <= load_mem[rd_addr];
        rd_speed_reg <= speed_mem[rd_addr];
        rd_written_reg <= written_reg[rd_addr];
        rd_addr_reg <= rd_addr;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg <= req_data[0];
            idx_reg <= req_data[6:1];
            bg_reg <= req_data[38:7];
            spd_reg <= req_data[54:39];
            avail_reg <= req_data[55];
            id_reg <= req_data[71:56];
            otime_reg <= req_data[103:72];
            cur_reg <= req_data[109:104];
            mig_reg <= req_data[110];
        end
    end

    // scan: address cnt, data arrives in the following cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_valid_reg <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            cnt_reg <= '0;
            rd_valid_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            if (cnt_reg != lim_reg)
                cnt_reg <= cnt_reg + CW'(1);
            rd_valid_reg <= (cnt_reg != lim_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            lim_reg <= lim_next;
            best_reg <= '0;
            best_load_reg <= '1;
        end
        else if (cmd.scan_step && rd_valid_reg)
        begin
            if (rd_addr_reg == '0 || rd_load_eff < best_load_reg)
            begin
                best_reg <= rd_addr_reg;
                best_load_reg <= rd_load_eff;
                dsp_reg <= (rd_written_reg && rd_speed_reg != '0) ? rd_speed_reg : 16'd1;
            end
        end
    end

    // current pe may be outside the active range: fetch its speed separately
    logic [glla_pkg::SPEED_W-1:0] cur_speed_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
            cur_speed_reg <= (cur_ok && written_reg[cur_reg[AW-1:0]])
                ? speed_mem[cur_reg[AW-1:0]] : 16'd1;
    end

    assign sts.scan_done = cmd.scan_step && !rd_valid_reg && (cnt_reg == lim_reg);

    assign rem_sh = {rem_reg[glla_pkg::SPEED_W-1:0], prod_reg[PW-1]};
    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
            prod_reg <= otime_reg * cur_speed_reg;
        else if (cmd.div_start)
        begin
            rem_reg <= '0;
            quot_reg <= '0;
            dcnt_reg <= DCW'(PW);
        end
        else if (cmd.div_step)
        begin
            prod_reg <= {prod_reg[PW-2:0], 1'b0};
            if (rem_sh >= {1'b0, dsp_reg})
            begin
                rem_reg <= rem_sh - {1'b0, dsp_reg};
                quot_reg <= {quot_reg[PW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quot_reg <= {quot_reg[PW-2:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg - DCW'(1);
        end
    end
    assign sts.div_done = (dcnt_reg == '0);

    assign sum = {{(PW-glla_pkg::LOAD_W+1){1'b0}}, best_load_reg} + {1'b0, quot_reg};
    assign new_load = (sum[PW:glla_pkg::LOAD_W] != '0) ? '1 : sum[glla_pkg::LOAD_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (mig_reg)
                res_reg <= {7'd0, glla_pkg::ST_PLACED,
                            ({{(32-AW){1'b0}}, best_reg} != {26'd0, cur_reg}),
                            glla_pkg::IDX_W'(best_reg), id_reg};
            else
                res_reg <= {7'd0,
                            (cur_ok && ready_reg[cur_reg[AW-1:0]]) ? glla_pkg::ST_KEPT
                                                                   : glla_pkg::ST_ERROR,
                            1'b0, cur_reg, id_reg};
        end
    end

    assign res_data = res_reg;
    assign sts.is_setup = (op_reg == glla_pkg::OP_SETUP);
    assign sts.mig = mig_reg;
endmodule

/* hw/rtl/glla_ctrl.sv */
// controller state machine and stream handshakes
module glla_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  glla_pkg::glla_sts_t sts,
    output glla_pkg::glla_cmd_t cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_MUL = 3'd3;
    localparam logic [2:0] S_DIVI = 3'd4;
    localparam logic [2:0] S_DIV = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] state_reg, state_next;
    logic mval_reg, mval_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mval_reg;

    always_comb
    begin
        state_next = state_reg;
        mval_next = mval_reg && !m_tready;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load_req = s_tvalid;
                if (s_tvalid)
                    state_next = S_DEC;
            end
            S_DEC:
            begin
                if (sts.is_setup)
                begin
                    cmd.setup_wr = 1'b1;
                    state_next = S_IDLE;
                end
                else if (!sts.mig)
                    state_next = S_DONE;
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_start = 1'b1;
                state_next = S_DIVI;
            end
            S_DIVI:
            begin
                cmd.div_start = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_done)
                    state_next = S_DONE;
                else
                    cmd.div_step = 1'b1;
            end
            S_DONE:
            begin
                if (!mval_reg || m_tready)
                begin
                    cmd.commit = sts.mig;
                    cmd.out_load = 1'b1;
                    mval_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mval_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mval_reg <= mval_next;
        end
    end
endmodule
